FILE: src/clock_sweep_cache_assert.svh
// Assertion macros for the checker file.
`ifndef CLOCK_SWEEP_CACHE_ASSERT_SVH
`define CLOCK_SWEEP_CACHE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CSC_ASSERT_NOW(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CSC_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: src/csc_pkg.sv
package csc_pkg;

    localparam int KEY_BITS     = 32;
    localparam int VALUE_BITS   = 32;
    localparam int CFG_BITS     = 5;
    localparam int IDX_OUT_BITS = 4;

    localparam logic [CFG_BITS-1:0] FRAMES_RESET = 5'd16;

    localparam logic FUNC_PUT = 1'b0;
    localparam logic FUNC_GET = 1'b1;

    typedef struct packed {
        logic                  func;
        logic [KEY_BITS-1:0]   key_in;
        logic [VALUE_BITS-1:0] value_in;
    } t_in_item;

    typedef struct packed {
        logic                    found;
        logic [VALUE_BITS-1:0]   value_out;
        logic [IDX_OUT_BITS-1:0] frame_index;
        logic                    replaced;
    } t_out_item;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

endpackage

FILE: src/csc_ram.sv
module csc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/clock_sweep_cache.sv
// Key/value cache with clock-sweep replacement.
// Input channel (i_in_valid / o_in_ready / i_in_data) carries one item: a put
// (func 0) stores key and value, a get (func 1) looks up a key. Every item
// yields one result item on the output channel (o_out_valid / i_out_ready /
// o_out_data). i_cfg_we writes frames_in_use (active frame count, 0 acts as 1,
// above DEPTH acts as DEPTH); the user must write it only while the block is
// idle, as the block itself does not enforce this.
// Operation: one frame is visited per cycle through the key, value and usage
// RAMs. A put starts at the clock hand and ages each valid frame with nonzero
// usage until it finds a victim; a get scans from frame 0 until it hits or
// reaches the last active frame. The next item can be taken in the same cycle
// as the result shows, if the receiver is ready for that result.
// One item is in work at a time; o_in_ready is low during the scan and while
// an undelivered result sits in the output register, so a stalled receiver
// holds back the input. Reset clears valid bits, clock hand, the output valid
// flag and sets frames_in_use to 16; key, value and usage RAMs are not
// cleared (entries are read only when their valid bit is set).
module clock_sweep_cache #(
    parameter int DEPTH     = 16,
    parameter int USAGE_MAX = 7
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  csc_pkg::t_in_item                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output csc_pkg::t_out_item                o_out_data,
    input  logic                              i_cfg_we,
    input  logic [csc_pkg::CFG_BITS-1:0]      i_cfg_wdata
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int UW = $clog2(USAGE_MAX + 1);
    localparam logic [IW-1:0] LAST_MAX = IW'(DEPTH - 1);
    localparam logic [UW-1:0] UMAX     = UW'(USAGE_MAX);

    csc_pkg::t_state    r_state, n_state;
    csc_pkg::t_in_item  r_item, n_item;
    csc_pkg::t_out_item r_out, n_out;
    logic               r_out_valid, n_out_valid;
    logic [IW-1:0]      r_p, n_p;
    logic [IW-1:0]      r_hand, n_hand;
    logic [DEPTH-1:0]   r_valid, n_valid;
    logic               r_fwd, n_fwd;
    logic [UW-1:0]      r_fwd_use, n_fwd_use;
    logic [csc_pkg::CFG_BITS-1:0] r_frames;

    logic [IW-1:0]      last_idx;
    logic [IW-1:0]      put_start;
    logic [IW-1:0]      p_next;
    logic [IW-1:0]      rd_addr;
    logic               kv_we;
    logic               use_we;
    logic [UW-1:0]      use_wdata;
    logic [UW-1:0]      use_rdata;
    logic [UW-1:0]      cur_use;
    logic [csc_pkg::KEY_BITS-1:0]   key_rdata;
    logic [csc_pkg::VALUE_BITS-1:0] value_rdata;
    logic               in_ready;

    csc_ram #(.WIDTH(csc_pkg::KEY_BITS), .DEPTH(DEPTH)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (kv_we),
        .i_waddr (r_p),
        .i_wdata (r_item.key_in),
        .i_raddr (rd_addr),
        .o_rdata (key_rdata)
    );

    csc_ram #(.WIDTH(csc_pkg::VALUE_BITS), .DEPTH(DEPTH)) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (kv_we),
        .i_waddr (r_p),
        .i_wdata (r_item.value_in),
        .i_raddr (rd_addr),
        .o_rdata (value_rdata)
    );

    csc_ram #(.WIDTH(UW), .DEPTH(DEPTH)) u_usage_ram (
        .i_clk   (i_clk),
        .i_we    (use_we),
        .i_waddr (r_p),
        .i_wdata (use_wdata),
        .i_raddr (rd_addr),
        .o_rdata (use_rdata)
    );

    always_comb begin
        if (r_frames == '0) begin
            last_idx = '0;
        end else if (int'(r_frames) > DEPTH) begin
            last_idx = LAST_MAX;
        end else begin
            last_idx = IW'(r_frames - 1'b1);
        end
    end

    assign put_start = (r_hand > last_idx) ? '0 : r_hand;
    assign p_next    = (r_p == last_idx) ? '0 : r_p + 1'b1;
    assign cur_use   = r_fwd ? r_fwd_use : use_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= csc_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_hand      <= '0;
            r_valid     <= '0;
            r_fwd       <= 1'b0;
            r_frames    <= csc_pkg::FRAMES_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_hand      <= n_hand;
            r_valid     <= n_valid;
            r_fwd       <= n_fwd;
            if (i_cfg_we) begin
                r_frames <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item    <= n_item;
        r_out     <= n_out;
        r_p       <= n_p;
        r_fwd_use <= n_fwd_use;
    end

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        n_p         = r_p;
        n_hand      = r_hand;
        n_valid     = r_valid;
        n_fwd       = 1'b0;
        n_fwd_use   = r_fwd_use;
        rd_addr     = r_p;
        kv_we       = 1'b0;
        use_we      = 1'b0;
        use_wdata   = cur_use;
        in_ready    = 1'b0;
        unique case (r_state)
            csc_pkg::ST_IDLE: begin
                in_ready = !r_out_valid || i_out_ready;
                if (i_in_valid && in_ready) begin
                    n_item  = i_in_data;
                    n_state = csc_pkg::ST_SCAN;
                    if (i_in_data.func == csc_pkg::FUNC_PUT) begin
                        n_p = put_start;
                    end else begin
                        n_p = '0;
                    end
                    rd_addr = n_p;
                end
            end
            csc_pkg::ST_SCAN: begin
                if (r_item.func == csc_pkg::FUNC_PUT) begin
                    if (!r_valid[r_p] || cur_use == '0) begin
                        kv_we             = 1'b1;
                        use_we            = 1'b1;
                        use_wdata         = UW'(1);
                        n_valid[r_p]      = 1'b1;
                        n_hand            = p_next;
                        n_out_valid       = 1'b1;
                        n_out.found       = 1'b0;
                        n_out.value_out   = '0;
                        n_out.frame_index = csc_pkg::IDX_OUT_BITS'(r_p);
                        n_out.replaced    = r_valid[r_p];
                        n_state           = csc_pkg::ST_IDLE;
                    end else begin
                        // age the frame and move on to the next frame
                        use_we    = 1'b1;
                        use_wdata = cur_use - 1'b1;
                        n_p       = p_next;
                        rd_addr   = p_next;
                        n_fwd     = (p_next == r_p);
                        n_fwd_use = cur_use - 1'b1;
                    end
                end else begin
                    if (r_valid[r_p] && key_rdata == r_item.key_in) begin
                        use_we            = 1'b1;
                        use_wdata         = (cur_use == UMAX) ? cur_use : cur_use + 1'b1;
                        n_out_valid       = 1'b1;
                        n_out.found       = 1'b1;
                        n_out.value_out   = value_rdata;
                        n_out.frame_index = csc_pkg::IDX_OUT_BITS'(r_p);
                        n_out.replaced    = 1'b0;
                        n_state           = csc_pkg::ST_IDLE;
                    end else if (r_p == last_idx) begin
                        n_out_valid       = 1'b1;
                        n_out.found       = 1'b0;
                        n_out.value_out   = '0;
                        n_out.frame_index = '0;
                        n_out.replaced    = 1'b0;
                        n_state           = csc_pkg::ST_IDLE;
                    end else begin
                        n_p     = r_p + 1'b1;
                        rd_addr = r_p + 1'b1;
                    end
                end
            end
            default: begin
                n_state = csc_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: src/csc_checker.sv
`include "clock_sweep_cache_assert.svh"

module csc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input csc_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input csc_pkg::t_out_item o_out_data
);

    `CSC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid, "result dropped while stalled")
    `CSC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "item accepted while scan busy")
    `CSC_ASSERT_NOW(a_miss_zero_value, i_clk, i_rst_n, o_out_valid && !o_out_data.found, o_out_data.value_out == '0, "nonzero value without hit")
    `CSC_ASSERT_NOW(a_hit_no_evict, i_clk, i_rst_n, o_out_valid && o_out_data.found, !o_out_data.replaced, "get result flags eviction")

endmodule

bind clock_sweep_cache csc_checker u_csc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

FILE: sim/testbench.sv
module testbench;

    localparam int DEPTH       = 16;
    localparam int USAGE_LIMIT = 7;
    localparam int PHASE_ITEMS = 65;
    localparam int LONG_HOLD   = 300;

    typedef struct {
        csc_pkg::t_in_item  it;
        int                 rep;
        bit                 typed;
        csc_pkg::t_out_item want;
    } t_row;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    csc_pkg::t_in_item            in_data = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    csc_pkg::t_out_item           out_data;
    logic                         cfg_we = 1'b0;
    logic [csc_pkg::CFG_BITS-1:0] cfg_wdata = '0;

    logic [csc_pkg::KEY_BITS-1:0]   slot_key[DEPTH];
    logic [csc_pkg::VALUE_BITS-1:0] slot_val[DEPTH];
    logic [2:0]                     slot_use[DEPTH];
    bit                             slot_valid[DEPTH];
    int                             hand;
    int                             frames_cfg;

    csc_pkg::t_out_item           lookup_q[$];
    t_row                         plan[$];
    logic [csc_pkg::KEY_BITS-1:0] key_pool[$];
    int                           errors = 0;
    bit                           hold_req = 1'b0;

    clock_sweep_cache dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int draw_gap(input bit quiet);
        return quiet ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic csc_pkg::t_out_item cache_apply(input csc_pkg::t_in_item it);
        csc_pkg::t_out_item r;
        int                 n;
        int                 h;
        int                 i;
        r = '0;
        n = (frames_cfg == 0) ? 1 : ((frames_cfg > DEPTH) ? DEPTH : frames_cfg);
        if (it.func == csc_pkg::FUNC_PUT) begin
            h = (hand < n) ? hand : 0;
            while (slot_valid[h] && slot_use[h] != 3'd0) begin
                slot_use[h] = slot_use[h] - 3'd1;
                h = (h + 1 >= n) ? 0 : h + 1;
            end
            r.replaced    = slot_valid[h];
            r.frame_index = 4'(h);
            slot_key[h]   = it.key_in;
            slot_val[h]   = it.value_in;
            slot_use[h]   = 3'd1;
            slot_valid[h] = 1'b1;
            hand = (h + 1 >= n) ? 0 : h + 1;
        end else begin
            for (i = 0; i < n; i++) begin
                if (!r.found && slot_valid[i] && slot_key[i] == it.key_in) begin
                    r.found       = 1'b1;
                    r.value_out   = slot_val[i];
                    r.frame_index = 4'(i);
                    if (slot_use[i] < USAGE_LIMIT)
                        slot_use[i] = slot_use[i] + 3'd1;
                end
            end
        end
        return r;
    endfunction

    task automatic report_miss(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        errors++;
    endtask

    task automatic check_result(input csc_pkg::t_out_item got);
        csc_pkg::t_out_item want;
        if (lookup_q.size() == 0) begin
            report_miss($sformatf("unexpected result item %h", got));
            return;
        end
        want = lookup_q.pop_front();
        if (got.found !== want.found)
            report_miss($sformatf("found got %b want %b", got.found, want.found));
        if (got.value_out !== want.value_out)
            report_miss($sformatf("value_out got %h want %h", got.value_out, want.value_out));
        if (got.frame_index !== want.frame_index)
            report_miss($sformatf("frame_index got %0d want %0d",
                                  got.frame_index, want.frame_index));
        if (got.replaced !== want.replaced)
            report_miss($sformatf("replaced got %b want %b", got.replaced, want.replaced));
    endtask

    // Call at a rising edge; returns at the edge where the item is taken.
    task automatic push_item(input csc_pkg::t_in_item it, input int gap, input bit typed,
                             input csc_pkg::t_out_item typed_want);
        csc_pkg::t_out_item pred;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        pred = cache_apply(it);
        lookup_q.push_back(typed ? typed_want : pred);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (lookup_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic add_row(input logic func, input logic [31:0] key, input logic [31:0] val,
                           input int rep, input bit typed, input logic found,
                           input logic [31:0] vout, input logic [3:0] idx, input logic repl);
        t_row row;
        row.it.func          = func;
        row.it.key_in        = key;
        row.it.value_in      = val;
        row.rep              = rep;
        row.typed            = typed;
        row.want.found       = found;
        row.want.value_out   = vout;
        row.want.frame_index = idx;
        row.want.replaced    = repl;
        plan.push_back(row);
    endtask

    // Receiver: random ready gaps, quiet stretches, one long hold on request.
    initial begin
        int  gap;
        int  served;
        bit  quiet;
        served = 0;
        quiet  = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever begin
            if (served % 37 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if (hold_req) begin
                hold_req = 1'b0;
                gap = LONG_HOLD;
            end else begin
                gap = draw_gap(quiet);
            end
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            check_result(out_data);
            served++;
        end
    end

    initial begin
        logic [csc_pkg::CFG_BITS-1:0] sizes[9];
        csc_pkg::t_in_item            it;
        int                           r;
        int                           k;
        int                           p;
        int                           gap;
        int                           burst;
        int                           pool_len;
        bit                           tx_quiet;

        sizes = '{5'd16, 5'd3, 5'd0, 5'd1, 5'd31, 5'd7, 5'd17, 5'd16, 5'd12};
        foreach (slot_valid[i]) begin
            slot_valid[i] = 1'b0;
            slot_use[i]   = 3'd0;
            slot_key[i]   = '0;
            slot_val[i]   = '0;
        end
        hand       = 0;
        frames_cfg = int'(csc_pkg::FRAMES_RESET);

        add_row(csc_pkg::FUNC_GET, 32'h0000_0000, 32'h1111_1111, 1, 1'b1,
                1'b0, 32'h0, 4'd0, 1'b0);
        add_row(csc_pkg::FUNC_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1'b1,
                1'b0, 32'h0, 4'd0, 1'b0);
        add_row(csc_pkg::FUNC_PUT, 32'h0000_0000, 32'h0000_0000, 1, 1'b1,
                1'b0, 32'h0, 4'd0, 1'b0);
        add_row(csc_pkg::FUNC_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1'b1,
                1'b0, 32'h0, 4'd1, 1'b0);
        add_row(csc_pkg::FUNC_GET, 32'h0000_0000, 32'hFFFF_FFFF, 1, 1'b1,
                1'b1, 32'h0, 4'd0, 1'b0);
        add_row(csc_pkg::FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1, 1'b1,
                1'b1, 32'hFFFF_FFFF, 4'd1, 1'b0);
        add_row(csc_pkg::FUNC_PUT, 32'hFFFF_FFFF, 32'h1234_5678, 1, 1'b0,
                1'b0, 32'h0, 4'd0, 1'b0);
        add_row(csc_pkg::FUNC_GET, 32'hFFFF_FFFF, 32'h0, 1, 1'b0, 1'b0, 32'h0, 4'd0, 1'b0);
        add_row(csc_pkg::FUNC_GET, 32'h0000_0000, 32'h0, 8, 1'b0, 1'b0, 32'h0, 4'd0, 1'b0);
        add_row(csc_pkg::FUNC_PUT, 32'hA5A5_5A5A, 32'h5A5A_A5A5, 2, 1'b0,
                1'b0, 32'h0, 4'd0, 1'b0);
        add_row(csc_pkg::FUNC_PUT, 32'h8000_0001, 32'h7FFF_FFFE, 1, 1'b0,
                1'b0, 32'h0, 4'd0, 1'b0);
        add_row(csc_pkg::FUNC_GET, 32'hA5A5_5A5A, 32'h0, 1, 1'b0, 1'b0, 32'h0, 4'd0, 1'b0);
        add_row(csc_pkg::FUNC_GET, 32'h8000_0001, 32'h0, 1, 1'b0, 1'b0, 32'h0, 4'd0, 1'b0);
        add_row(csc_pkg::FUNC_GET, 32'h0BAD_CAFE, 32'h0, 1, 1'b0, 1'b0, 32'h0, 4'd0, 1'b0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i]) begin
            for (r = 0; r < plan[i].rep; r++)
                push_item(plan[i].it, draw_gap(1'b0), plan[i].typed, plan[i].want);
        end

        burst    = 0;
        tx_quiet = 1'b0;
        for (p = 0; p < 9; p++) begin
            wait_idle();
            cfg_we    <= 1'b1;
            cfg_wdata <= sizes[p];
            @(posedge clk);
            cfg_we     <= 1'b0;
            frames_cfg = int'(sizes[p]);

            key_pool.delete();
            pool_len = $urandom_range(2, 20);
            repeat (pool_len) key_pool.push_back($urandom());
            if ($urandom_range(0, 1) == 1) key_pool.push_back(32'h0);
            if ($urandom_range(0, 1) == 1) key_pool.push_back(32'hFFFF_FFFF);

            for (k = 0; k < PHASE_ITEMS; k++) begin
                if (k % 40 == 0)
                    tx_quiet = ($urandom_range(0, 3) == 0);
                if (p == 0 && k == 20) begin
                    hold_req = 1'b1;
                    burst    = 30;
                end
                if (p == 3 && k == 30)
                    wait_idle();
                it.func = ($urandom_range(0, 99) < 45) ? csc_pkg::FUNC_PUT : csc_pkg::FUNC_GET;
                if ($urandom_range(0, 9) == 0)
                    it.key_in = $urandom();
                else
                    it.key_in = key_pool[$urandom_range(0, key_pool.size() - 1)];
                it.value_in = $urandom();
                if (burst > 0) begin
                    gap = 0;
                    burst--;
                end else begin
                    gap = draw_gap(tx_quiet);
                end
                push_item(it, gap, 1'b0, '0);
            end
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
